### rtl/text_console_cursor_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor engine
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define TCCE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition never occurs
`define TCCE_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, codes and default sizes shared by the text console engine modules.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // Default geometry
   localparam int DEF_SCREEN_WIDTH  = 80;
   localparam int DEF_SCREEN_HEIGHT = 25;
   localparam int DEF_SCREEN_COUNT  = 4;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Operation codes
   localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
   localparam logic [2:0] OP_SET_COLOUR = 3'd1;
   localparam logic [2:0] OP_SWITCH     = 3'd2;
   localparam logic [2:0] OP_CLEAR      = 3'd3;
   localparam logic [2:0] OP_READ_CELL  = 3'd4;

   // Control characters
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;

   localparam logic [7:0] RESET_COLOUR = 8'h07;
   localparam int         TAB_STOP     = 4;

   typedef enum logic [3:0] {
      K_PLAIN,
      K_TAB,
      K_NEWLINE,
      K_RETURN,
      K_BACKSPACE,
      K_COLOUR,
      K_SWITCH,
      K_CLEAR,
      K_READ,
      K_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [7:0]   colour;
      logic [2:0]   screen;
      logic [10:0]  index;
   } cmd_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_PUT,
      S_ERASE,
      S_SCROLL_START,
      S_SCROLL_MOVE,
      S_FILL,
      S_READ_WAIT,
      S_DONE
   } back_state_type;

endpackage

### rtl/text_console_cursor_engine_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Multi-screen character-cell text console with per-screen cursor and colour.
// ----------------------------------------------------------------------------
// Each request returns exactly one response. After reset the cell store is
// blanked one cell per cycle, with req_stall held high. The front queues up
// to two requests while the back works. A scroll moves each cell one row up
// and blanks the bottom row, and a clear blanks the screen, one cell per
// cycle in both cases.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
   parameter int SCREEN_WIDTH  = tcce_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcce_pkg::DEF_SCREEN_HEIGHT,
   parameter int SCREEN_COUNT  = tcce_pkg::DEF_SCREEN_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [3:0]  req_foreground,
   input  logic [3:0]  req_background,
   input  logic [2:0]  req_screen_select,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   output logic [2:0]  rsp_active_index,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_scrolled
);
   import tcce_pkg::*;

   logic    init_busy;
   logic    q_full, q_empty, q_push, q_pop;
   cmd_type push_cmd, head_cmd;

   // Classify requests
   tcce_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .SCREEN_COUNT  (SCREEN_COUNT)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_foreground    (req_foreground),
      .req_background    (req_background),
      .req_screen_select (req_screen_select),
      .req_cell_index    (req_cell_index),
      .init_busy         (init_busy),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   // Buffer commands
   tcce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Execute commands
   tcce_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .SCREEN_COUNT  (SCREEN_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (head_cmd),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .init_busy        (init_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_active_index (rsp_active_index),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_scrolled     (rsp_scrolled)
   );

endmodule

### rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Takes requests, classifies them into engine commands and queues them.
// ----------------------------------------------------------------------------
module tcce_front #(
   parameter int SCREEN_WIDTH  = tcce_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcce_pkg::DEF_SCREEN_HEIGHT,
   parameter int SCREEN_COUNT  = tcce_pkg::DEF_SCREEN_COUNT
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_operation,
   input  logic [7:0]        req_char_code,
   input  logic [3:0]        req_foreground,
   input  logic [3:0]        req_background,
   input  logic [2:0]        req_screen_select,
   input  logic [10:0]       req_cell_index,
   input  logic              init_busy,
   input  logic              q_full,
   output logic              q_push,
   output tcce_pkg::cmd_type q_cmd
);
   import tcce_pkg::*;

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;

   // Hold requests while the store is being initialized or the queue is full
   assign req_stall = init_busy | q_full;
   assign q_push    = req_valid & ~req_stall;

   // Classify the request
   always_comb begin
      q_cmd.kind      = K_NOP;
      q_cmd.char_code = req_char_code;
      q_cmd.colour    = {req_background, req_foreground};
      q_cmd.screen    = req_screen_select;
      q_cmd.index     = req_cell_index;
      unique case (req_operation)
         OP_PUT_CHAR: begin
            unique case (req_char_code)
               CH_NEWLINE:   q_cmd.kind = K_NEWLINE;
               CH_RETURN:    q_cmd.kind = K_RETURN;
               CH_BACKSPACE: q_cmd.kind = K_BACKSPACE;
               CH_TAB: begin
                  q_cmd.kind      = K_TAB;
                  q_cmd.char_code = BLANK_CHAR;
               end
               default:      q_cmd.kind = K_PLAIN;
            endcase
         end
         OP_SET_COLOUR: q_cmd.kind = K_COLOUR;
         OP_SWITCH: begin
            if (32'(req_screen_select) < 32'(SCREEN_COUNT)) begin
               q_cmd.kind = K_SWITCH;
            end
         end
         OP_CLEAR: q_cmd.kind = K_CLEAR;
         OP_READ_CELL: begin
            if (32'(req_cell_index) < 32'(CELLS)) begin
               q_cmd.kind = K_READ;
            end
         end
         default: q_cmd.kind = K_NOP;
      endcase
   end

endmodule

### rtl/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_top_assert.svh"

module tcce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcce_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tcce_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);
   import tcce_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TCCE_ASSERT_NEVER(a_push_when_full, clock, reset, push && full, "queue overflow")
   `TCCE_ASSERT_NEVER(a_pop_when_empty, clock, reset, pop && empty, "queue underflow")

endmodule

### rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Command executor: cell store, per-screen cursors and colours, scrolling,
// clearing and the registered response.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_top_assert.svh"

module tcce_back #(
   parameter int SCREEN_WIDTH  = tcce_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcce_pkg::DEF_SCREEN_HEIGHT,
   parameter int SCREEN_COUNT  = tcce_pkg::DEF_SCREEN_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  tcce_pkg::cmd_type q_head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              init_busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [4:0]        rsp_cursor_row,
   output logic [6:0]        rsp_cursor_col,
   output logic [2:0]        rsp_active_index,
   output logic [15:0]       rsp_cell_data,
   output logic              rsp_scrolled
);
   import tcce_pkg::*;

   localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int DEPTH     = SCREEN_COUNT * CELLS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
   localparam int COL_W     = $clog2(SCREEN_WIDTH);
   localparam int SCR_W     = (SCREEN_COUNT > 1) ? $clog2(SCREEN_COUNT) : 1;
   localparam int MOVE_SPAN = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);

   // Cell store
   logic [15:0]        cell_mem [DEPTH];
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [15:0]        mem_wd;
   logic [ADDR_W-1:0]  rd_addr;
   logic [15:0]        rd_data_ff;

   // Per-screen state
   logic [ROW_W-1:0]   row_ff    [SCREEN_COUNT];
   logic [COL_W-1:0]   col_ff    [SCREEN_COUNT];
   logic [7:0]         colour_ff [SCREEN_COUNT];
   logic               cursor_we, colour_we;
   logic [ROW_W-1:0]   row_in;
   logic [COL_W-1:0]   col_in;
   logic [7:0]         colour_in;

   back_state_type     state_ff, state_in;
   logic [SCR_W-1:0]   active_ff, active_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  end_ff, end_in;
   cmd_type            cmd_ff, cmd_in;
   logic [2:0]         tab_left_ff, tab_left_in;
   logic               scrolled_ff, scrolled_in;
   logic [15:0]        data_ff, data_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_row_ff, rsp_row_in;
   logic [6:0]         rsp_col_ff, rsp_col_in;
   logic [2:0]         rsp_active_ff, rsp_active_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   logic [ROW_W-1:0]   cur_row;
   logic [COL_W-1:0]   cur_col;
   logic [7:0]         cur_colour;
   logic [ADDR_W-1:0]  cur_addr;
   logic               rsp_free;

   assign cur_row    = row_ff[active_ff];
   assign cur_col    = col_ff[active_ff];
   assign cur_colour = colour_ff[active_ff];
   assign cur_addr   = base_ff + ADDR_W'(cur_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_col);
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   assign init_busy  = (state_ff == S_INIT);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_active_index = rsp_active_ff;
   assign rsp_cell_data    = rsp_data_ff;
   assign rsp_scrolled     = rsp_scrolled_ff;

   // Next state and datapath control
   always_comb begin
      state_in        = state_ff;
      active_in       = active_ff;
      base_in         = base_ff;
      addr_in         = addr_ff;
      end_in          = end_ff;
      cmd_in          = cmd_ff;
      tab_left_in     = tab_left_ff;
      scrolled_in     = scrolled_ff;
      data_in         = data_ff;
      q_pop           = 1'b0;
      mem_we          = 1'b0;
      mem_wa          = addr_ff;
      mem_wd          = {cur_colour, BLANK_CHAR};
      rd_addr         = addr_ff;
      cursor_we       = 1'b0;
      row_in          = cur_row;
      col_in          = cur_col;
      colour_we       = 1'b0;
      colour_in       = cmd_ff.colour;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scrolled_in = rsp_scrolled_ff;

      unique case (state_ff)
         // Blank every cell of every screen after reset
         S_INIT: begin
            mem_we = 1'b1;
            mem_wd = {RESET_COLOUR, BLANK_CHAR};
            if (addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               cmd_in      = q_head;
               scrolled_in = 1'b0;
               data_in     = '0;
               state_in    = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (cmd_ff.kind)
               K_PLAIN: begin
                  tab_left_in = 3'd1;
                  state_in    = S_PUT;
               end
               K_TAB: begin
                  tab_left_in = 3'(TAB_STOP) - 3'(cur_col % TAB_STOP);
                  state_in    = S_PUT;
               end
               K_NEWLINE: begin
                  cursor_we   = 1'b1;
                  col_in      = '0;
                  tab_left_in = 3'd1;
                  if (cur_row == ROW_LAST) begin
                     state_in = S_SCROLL_START;
                  end else begin
                     row_in   = cur_row + 1'b1;
                     state_in = S_DONE;
                  end
               end
               K_RETURN: begin
                  cursor_we = 1'b1;
                  col_in    = '0;
                  state_in  = S_DONE;
               end
               K_BACKSPACE: begin
                  cursor_we = 1'b1;
                  if (cur_col != '0) begin
                     col_in = cur_col - 1'b1;
                  end else if (cur_row != '0) begin
                     row_in = cur_row - 1'b1;
                     col_in = COL_LAST;
                  end
                  state_in = S_ERASE;
               end
               K_COLOUR: begin
                  colour_we = 1'b1;
                  state_in  = S_DONE;
               end
               K_SWITCH: begin
                  active_in = SCR_W'(cmd_ff.screen);
                  base_in   = ADDR_W'(cmd_ff.screen) * ADDR_W'(CELLS);
                  state_in  = S_DONE;
               end
               K_CLEAR: begin
                  cursor_we   = 1'b1;
                  row_in      = '0;
                  col_in      = '0;
                  addr_in     = base_ff;
                  end_in      = base_ff + ADDR_W'(CELLS - 1);
                  tab_left_in = 3'd1;
                  state_in    = S_FILL;
               end
               K_READ: begin
                  rd_addr  = base_ff + ADDR_W'(cmd_ff.index);
                  state_in = S_READ_WAIT;
               end
               default: state_in = S_DONE;
            endcase
         end

         // Store one character and advance the cursor
         S_PUT: begin
            mem_we    = 1'b1;
            mem_wa    = cur_addr;
            mem_wd    = {cur_colour, cmd_ff.char_code};
            cursor_we = 1'b1;
            if (cur_col == COL_LAST) begin
               col_in = '0;
               if (cur_row == ROW_LAST) begin
                  state_in = S_SCROLL_START;
               end else begin
                  row_in = cur_row + 1'b1;
               end
            end else begin
               col_in = cur_col + 1'b1;
            end
            if (!(cur_col == COL_LAST && cur_row == ROW_LAST)) begin
               if (tab_left_ff == 3'd1) begin
                  state_in = S_DONE;
               end else begin
                  tab_left_in = tab_left_ff - 1'b1;
               end
            end
         end

         // Blank the cell under the cursor after backing up
         S_ERASE: begin
            mem_we   = 1'b1;
            mem_wa   = cur_addr;
            state_in = S_DONE;
         end

         // Prime the row move with the first source cell
         S_SCROLL_START: begin
            rd_addr     = base_ff + ADDR_W'(SCREEN_WIDTH);
            addr_in     = base_ff;
            end_in      = base_ff + ADDR_W'(MOVE_SPAN - 1);
            scrolled_in = 1'b1;
            state_in    = S_SCROLL_MOVE;
         end

         // Copy each cell one row up, reading the next source meanwhile
         S_SCROLL_MOVE: begin
            mem_we  = 1'b1;
            mem_wd  = rd_data_ff;
            rd_addr = addr_ff + ADDR_W'(SCREEN_WIDTH + 1);
            addr_in = addr_ff + 1'b1;
            if (addr_ff == end_ff) begin
               end_in   = base_ff + ADDR_W'(CELLS - 1);
               state_in = S_FILL;
            end
         end

         // Blank a run of cells in the screen colour
         S_FILL: begin
            mem_we = 1'b1;
            if (addr_ff == end_ff) begin
               if (tab_left_ff == 3'd1) begin
                  state_in = S_DONE;
               end else begin
                  tab_left_in = tab_left_ff - 1'b1;
                  state_in    = S_PUT;
               end
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         S_READ_WAIT: begin
            data_in  = rd_data_ff;
            state_in = S_DONE;
         end

         // Load the response once the output register is free
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_row_in      = 5'(cur_row);
               rsp_col_in      = 7'(cur_col);
               rsp_active_in   = 3'(active_ff);
               rsp_data_in     = data_ff;
               rsp_scrolled_in = scrolled_ff;
               state_in        = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         base_ff      <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SCREEN_COUNT; i++) begin
            row_ff[i]    <= '0;
            col_ff[i]    <= '0;
            colour_ff[i] <= RESET_COLOUR;
         end
      end else begin
         active_ff    <= active_in;
         base_ff      <= base_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cursor_we) begin
            row_ff[active_ff] <= row_in;
            col_ff[active_ff] <= col_in;
         end
         if (colour_we) begin
            colour_ff[active_ff] <= colour_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      end_ff          <= end_in;
      cmd_ff          <= cmd_in;
      tab_left_ff     <= tab_left_in;
      scrolled_ff     <= scrolled_in;
      data_ff         <= data_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_active_ff   <= rsp_active_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   // Cell store ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= cell_mem[rd_addr];
   end

   `TCCE_ASSERT_IMPLY(a_no_pop_in_init, clock, reset, state_ff == S_INIT, !q_pop,
      "command taken during store initialization")
   `TCCE_ASSERT_IMPLY(a_sweep_in_screen, clock, reset,
      state_ff == S_FILL || state_ff == S_SCROLL_MOVE,
      addr_ff >= base_ff && addr_ff <= end_ff, "sweep left the active screen")
   `TCCE_ASSERT_IMPLY(a_cursor_on_screen, clock, reset, state_ff != S_INIT,
      cur_row <= ROW_LAST && cur_col <= COL_LAST, "cursor off screen")
   `TCCE_ASSERT_IMPLY(a_scroll_bottom_row, clock, reset, rsp_valid_ff && rsp_scrolled_ff,
      rsp_row_ff == 5'(ROW_LAST), "scroll response not on bottom row")

endmodule

### sim/text_console_cursor_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console result checker
// Watches both channels of the console, keeps its own copy of every screen,
// cursor and colour, predicts the status returned for each accepted request
// and compares it with the status the console sends back.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_checker #(
   parameter int SCREEN_WIDTH  = tcce_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcce_pkg::DEF_SCREEN_HEIGHT,
   parameter int SCREEN_COUNT  = tcce_pkg::DEF_SCREEN_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [3:0]  req_foreground,
   input  logic [3:0]  req_background,
   input  logic [2:0]  req_screen_select,
   input  logic [10:0] req_cell_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_cursor_row,
   input  logic [6:0]  rsp_cursor_col,
   input  logic [2:0]  rsp_active_index,
   input  logic [15:0] rsp_cell_data,
   input  logic        rsp_scrolled,
   output int          fail_count,
   output int          outstanding
);
   import tcce_pkg::*;

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;

   typedef struct packed {
      logic [4:0]  row;
      logic [6:0]  col;
      logic [2:0]  screen;
      logic [15:0] data;
      logic        scrolled;
   } console_status_type;

   // Shadow console state
   logic [15:0] cell_store [SCREEN_COUNT * CELLS];
   int          cur_row [SCREEN_COUNT];
   int          cur_col [SCREEN_COUNT];
   logic [7:0]  screen_attr [SCREEN_COUNT];
   int          active_screen;
   logic        step_scrolled;

   console_status_type expected_status_q[$];
   console_status_type oldest_status;
   int                 mismatches = 0;
   int                 result_count = 0;

   // Move to the start of the next row, scroll the screen up past the bottom
   task automatic advance_line(input int s);
      cur_col[s] = 0;
      cur_row[s]++;
      if (cur_row[s] >= SCREEN_HEIGHT) begin
         for (int i = 0; i < (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i++)
            cell_store[s * CELLS + i] = cell_store[s * CELLS + i + SCREEN_WIDTH];
         for (int i = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i < CELLS; i++)
            cell_store[s * CELLS + i] = {screen_attr[s], BLANK_CHAR};
         cur_row[s] = SCREEN_HEIGHT - 1;
         step_scrolled = 1'b1;
      end
   endtask

   // Store one glyph at the cursor and advance, wrapping at the line end
   task automatic write_glyph(input int s, input logic [7:0] ch);
      cell_store[s * CELLS + cur_row[s] * SCREEN_WIDTH + cur_col[s]] = {screen_attr[s], ch};
      cur_col[s]++;
      if (cur_col[s] >= SCREEN_WIDTH)
         advance_line(s);
   endtask

   // Apply one request to the shadow console and queue the status it returns
   task automatic execute_command(input logic [2:0] op, input logic [7:0] ch,
                                  input logic [3:0] fg, input logic [3:0] bg,
                                  input logic [2:0] sel, input logic [10:0] idx);
      console_status_type st;
      int                 s;
      int                 spaces;
      s = active_screen;
      st.data = '0;
      step_scrolled = 1'b0;
      case (op)
         OP_PUT_CHAR: begin
            case (ch)
               CH_NEWLINE: advance_line(s);
               CH_RETURN: cur_col[s] = 0;
               CH_TAB: begin
                  spaces = TAB_STOP - (cur_col[s] % TAB_STOP);
                  repeat (spaces) write_glyph(s, BLANK_CHAR);
               end
               CH_BACKSPACE: begin
                  if (cur_col[s] > 0) begin
                     cur_col[s]--;
                  end else if (cur_row[s] > 0) begin
                     cur_row[s]--;
                     cur_col[s] = SCREEN_WIDTH - 1;
                  end
                  cell_store[s * CELLS + cur_row[s] * SCREEN_WIDTH + cur_col[s]] =
                     {screen_attr[s], BLANK_CHAR};
               end
               default: write_glyph(s, ch);
            endcase
         end
         OP_SET_COLOUR: screen_attr[s] = {bg, fg};
         OP_SWITCH: begin
            if (sel < SCREEN_COUNT && sel != active_screen)
               active_screen = int'(sel);
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               cell_store[s * CELLS + i] = {screen_attr[s], BLANK_CHAR};
            cur_row[s] = 0;
            cur_col[s] = 0;
         end
         OP_READ_CELL: begin
            if (idx < CELLS)
               st.data = cell_store[s * CELLS + idx];
         end
         default: ;
      endcase
      s = active_screen;
      st.row = 5'(cur_row[s]);
      st.col = 7'(cur_col[s]);
      st.screen = 3'(s);
      st.scrolled = step_scrolled;
      expected_status_q.push_back(st);
   endtask

   // Track both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCREEN_COUNT * CELLS; i++)
            cell_store[i] = {RESET_COLOUR, BLANK_CHAR};
         for (int i = 0; i < SCREEN_COUNT; i++) begin
            cur_row[i] = 0;
            cur_col[i] = 0;
            screen_attr[i] = RESET_COLOUR;
         end
         active_screen = 0;
         expected_status_q.delete();
      end else begin
         // Compare a delivered status with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_status_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result %0d arrived with no request pending: row %0d col %0d",
                           $realtime, result_count, rsp_cursor_row, rsp_cursor_col);
            end else begin
               oldest_status = expected_status_q.pop_front();
               if (rsp_cursor_row !== oldest_status.row ||
                   rsp_cursor_col !== oldest_status.col ||
                   rsp_active_index !== oldest_status.screen ||
                   rsp_cell_data !== oldest_status.data ||
                   rsp_scrolled !== oldest_status.scrolled) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] #%0d exp row %0d col %0d screen %0d cell %h scrolled %b",
                              $realtime, result_count, oldest_status.row, oldest_status.col,
                              oldest_status.screen, oldest_status.data,
                              oldest_status.scrolled);
                     $display("[%0t] #%0d got row %0d col %0d screen %0d cell %h scrolled %b",
                              $realtime, result_count, rsp_cursor_row, rsp_cursor_col,
                              rsp_active_index, rsp_cell_data, rsp_scrolled);
                  end
               end
            end
         end
         // Predict the status of an accepted request
         if (req_valid && !req_stall)
            execute_command(req_operation, req_char_code, req_foreground, req_background,
                            req_screen_select, req_cell_index);
      end
      fail_count <= mismatches;
      outstanding <= expected_status_q.size();
   end

endmodule

### sim/text_console_cursor_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console testbench
// Drives directed and random console requests with random gaps and response
// stalls, including long hold-offs that back the console up, and reports the
// verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top_tb;
   import tcce_pkg::*;

   localparam int         CELL_COUNT   = DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT;
   localparam logic [2:0] OP_LAST_CODE = 3'd7;
   localparam int         RANDOM_ITEMS = 300;
   localparam int         DRAIN_CYCLES = 2100;
   localparam int         HOLD_CYCLES  = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [7:0]  req_char_code;
   logic [3:0]  req_foreground;
   logic [3:0]  req_background;
   logic [2:0]  req_screen_select;
   logic [10:0] req_cell_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_col;
   logic [2:0]  rsp_active_index;
   logic [15:0] rsp_cell_data;
   logic        rsp_scrolled;
   int          fail_count;
   int          outstanding;

   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   int sent_count = 0;

   text_console_cursor_engine_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_foreground    (req_foreground),
      .req_background    (req_background),
      .req_screen_select (req_screen_select),
      .req_cell_index    (req_cell_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_active_index  (rsp_active_index),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_scrolled      (rsp_scrolled)
   );

   text_console_cursor_engine_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_foreground    (req_foreground),
      .req_background    (req_background),
      .req_screen_select (req_screen_select),
      .req_cell_index    (req_cell_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_active_index  (rsp_active_index),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_scrolled      (rsp_scrolled),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always #4 clock = ~clock;

   // Random values for fields that a command ignores
   function automatic logic [7:0] rand_char();
      return 8'($urandom);
   endfunction

   function automatic logic [3:0] rand_colour();
      return 4'($urandom);
   endfunction

   function automatic logic [2:0] rand_screen();
      return 3'($urandom);
   endfunction

   function automatic logic [10:0] rand_index();
      return 11'($urandom);
   endfunction

   // Offer one request, after a random gap while the sender is idle, and hold it until accepted
   task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch,
                           input logic [3:0] fg, input logic [3:0] bg,
                           input logic [2:0] sel, input logic [10:0] idx);
      int gap;
      gap = sender_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_char_code <= ch;
      req_foreground <= fg;
      req_background <= bg;
      req_screen_select <= sel;
      req_cell_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // Response side: random stalls, plus two long hold-offs to back up the input
   initial begin
      int hold;
      int accepted;
      accepted = 0;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (accepted == 5 || accepted == 150)
            hold = HOLD_CYCLES;
         else
            hold = receiver_idle ? $urandom_range(0, 17) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         accepted++;
         if (accepted % 20 == 0)
            receiver_idle = ($urandom_range(0, 2) != 0);
         @(negedge clock);
      end
   end

   // Run limit
   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Request stimulus and verdict
   initial begin
      int         pick;
      int         run_len;
      int         r;
      logic [7:0] ch;
      logic [10:0] idx;
      req_valid = 1'b0;
      req_operation = OP_PUT_CHAR;
      req_char_code = '0;
      req_foreground = '0;
      req_background = '0;
      req_screen_select = '0;
      req_cell_index = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, control characters, switch and read corners
      send_cmd(OP_READ_CELL, rand_char(), rand_colour(), rand_colour(), rand_screen(), 11'd0);
      send_cmd(OP_READ_CELL, rand_char(), rand_colour(), rand_colour(), rand_screen(),
               11'(CELL_COUNT - 1));
      send_cmd(OP_READ_CELL, rand_char(), rand_colour(), rand_colour(), rand_screen(), 11'h7FF);
      send_cmd(OP_PUT_CHAR, 8'hFF, rand_colour(), rand_colour(), rand_screen(), rand_index());
      send_cmd(OP_SET_COLOUR, rand_char(), 4'hF, 4'hF, rand_screen(), rand_index());
      send_cmd(OP_PUT_CHAR, 8'h00, rand_colour(), rand_colour(), rand_screen(), rand_index());
      send_cmd(OP_PUT_CHAR, CH_BACKSPACE, rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      send_cmd(OP_SET_COLOUR, rand_char(), 4'h0, 4'h0, rand_screen(), rand_index());
      send_cmd(OP_PUT_CHAR, CH_BACKSPACE, rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      // backspace in the top-left cell keeps the cursor and blanks the cell
      send_cmd(OP_PUT_CHAR, CH_BACKSPACE, rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      send_cmd(OP_READ_CELL, rand_char(), rand_colour(), rand_colour(), rand_screen(), 11'd0);
      send_cmd(OP_PUT_CHAR, CH_TAB, rand_colour(), rand_colour(), rand_screen(), rand_index());
      send_cmd(OP_PUT_CHAR, CH_RETURN, rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      send_cmd(OP_PUT_CHAR, CH_NEWLINE, rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      // back up across the line start, then tab over the line end
      send_cmd(OP_PUT_CHAR, CH_BACKSPACE, rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      send_cmd(OP_PUT_CHAR, CH_TAB, rand_colour(), rand_colour(), rand_screen(), rand_index());
      send_cmd(OP_READ_CELL, rand_char(), rand_colour(), rand_colour(), rand_screen(),
               11'(DEF_SCREEN_WIDTH - 1));
      // switch out of range, to the active screen, then to a real one
      send_cmd(OP_SWITCH, rand_char(), rand_colour(), rand_colour(), 3'h7, rand_index());
      send_cmd(OP_SWITCH, rand_char(), rand_colour(), rand_colour(), 3'h0, rand_index());
      send_cmd(OP_SWITCH, rand_char(), rand_colour(), rand_colour(),
               3'(DEF_SCREEN_COUNT - 1), rand_index());
      send_cmd(OP_PUT_CHAR, 8'($urandom_range(33, 126)), rand_colour(), rand_colour(),
               rand_screen(), rand_index());
      send_cmd(OP_CLEAR, rand_char(), rand_colour(), rand_colour(), rand_screen(),
               rand_index());
      send_cmd(OP_SWITCH, rand_char(), rand_colour(), rand_colour(), 3'(DEF_SCREEN_COUNT),
               rand_index());
      for (int op = OP_READ_CELL + 1; op <= OP_LAST_CODE; op++)
         send_cmd(3'(op), rand_char(), rand_colour(), rand_colour(), rand_screen(),
                  rand_index());

      // Random runs of text, newlines, reads and screen control
      sent_count = 0;
      while (sent_count < RANDOM_ITEMS) begin
         sender_idle = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(81, 120)
                                                  : $urandom_range(4, 40);
            repeat (run_len) begin
               r = $urandom_range(0, 99);
               if (r < 8)
                  ch = CH_NEWLINE;
               else if (r < 12)
                  ch = CH_RETURN;
               else if (r < 20)
                  ch = CH_TAB;
               else if (r < 28)
                  ch = CH_BACKSPACE;
               else
                  ch = 8'($urandom_range(0, 255));
               send_cmd(OP_PUT_CHAR, ch, rand_colour(), rand_colour(), rand_screen(),
                        rand_index());
            end
         end else if (pick < 55) begin
            // push the cursor toward the bottom row and scroll
            repeat ($urandom_range(5, 30)) begin
               ch = ($urandom_range(0, 99) < 85) ? CH_NEWLINE : 8'($urandom_range(0, 255));
               send_cmd(OP_PUT_CHAR, ch, rand_colour(), rand_colour(), rand_screen(),
                        rand_index());
            end
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 4)) begin
               r = $urandom_range(0, 99);
               if (r < 45)
                  idx = 11'($urandom_range(0, CELL_COUNT - 1));
               else if (r < 70)
                  idx = 11'($urandom_range(CELL_COUNT - DEF_SCREEN_WIDTH, CELL_COUNT - 1));
               else if (r < 85)
                  idx = 11'($urandom_range(0, DEF_SCREEN_WIDTH - 1));
               else
                  idx = 11'($urandom_range(CELL_COUNT, 2047));
               send_cmd(OP_READ_CELL, rand_char(), rand_colour(), rand_colour(),
                        rand_screen(), idx);
            end
         end else if (pick < 78) begin
            send_cmd(OP_SET_COLOUR, rand_char(), rand_colour(), rand_colour(), rand_screen(),
                     rand_index());
         end else if (pick < 88) begin
            send_cmd(OP_SWITCH, rand_char(), rand_colour(), rand_colour(), rand_screen(),
                     rand_index());
         end else if (pick < 92) begin
            send_cmd(OP_CLEAR, rand_char(), rand_colour(), rand_colour(), rand_screen(),
                     rand_index());
         end else if (pick < 96) begin
            send_cmd(3'($urandom_range(int'(OP_READ_CELL) + 1, int'(OP_LAST_CODE))),
                     rand_char(), rand_colour(), rand_colour(), rand_screen(), rand_index());
         end else begin
            repeat ($urandom_range(1, 6)) begin
               ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(32, 126)) : CH_TAB;
               send_cmd(OP_PUT_CHAR, ch, rand_colour(), rand_colour(), rand_screen(),
                        rand_index());
            end
         end
      end
      req_valid <= 1'b0;

      // Drain the remaining responses, then watch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine_top.sv
sim/text_console_cursor_engine_checker.sv
sim/text_console_cursor_engine_top_tb.sv
